// ===== src/quadratic_root_solver_assert.svh =====
// Assertion macros for the quadratic root solver.
// Depends on nothing; the including module provides aclk and aresetn.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

`ifndef SYNTHESIS
`define QRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define QRS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define QRS_ASSERT(lbl, prop, msg)
`define QRS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== src/qrs_pkg.sv =====
// Package for the quadratic root solver: widths, codes and side-band types.
// Depends on nothing.
`default_nettype none

package qrs_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int COEF_W    = 32;
    localparam int DISC_W    = 66;
    localparam int SQ_W      = 34;
    localparam int SQ_TW     = 68;
    localparam int NUM_MAG_W = 35;
    localparam int DEN_W     = 33;

    localparam logic [15:0] COEF_TOL_RESET = 16'd1;
    localparam logic [31:0] DISC_TOL_RESET = 32'd42950;
    localparam logic [15:0] ROOT_TOL_RESET = 16'd1;

    typedef enum logic [2:0] {
        CLASS_NONE   = 3'd0,
        CLASS_TWO    = 3'd1,
        CLASS_LINEAR = 3'd2,
        CLASS_DOUBLE = 3'd3,
        CLASS_ALL    = 3'd4
    } root_class_t;

    typedef enum logic [1:0] {
        CFG_COEF_TOL = 2'd0,
        CFG_DISC_TOL = 2'd1,
        CFG_ROOT_TOL = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [COEF_W-1:0] a;
        logic [COEF_W-1:0] b;
        logic [COEF_W-1:0] c;
        logic              run_div;
        logic              lin;
        root_class_t       cls;
    } sq_side_t;

    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic             neg1;
        logic             neg2;
        logic             run_div;
        logic             lin;
        root_class_t      cls;
    } dv_side_t;

    function automatic logic [COEF_W-1:0] mag32(input logic [COEF_W-1:0] v);
        mag32 = v[COEF_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

`default_nettype wire

// ===== src/quadratic_root_solver.sv =====
// Quadratic root solver: pipelined discriminant, square root and dual divider.
// Depends on qrs_pkg and quadratic_root_solver_assert.svh.
// Register stages: 75 + FRAC_BITS in all (3 front stages, 34 square-root stages,
//   1 prep stage, 35 + FRAC_BITS divider stages, 2 back stages). Throughput: one
//   item per cycle while the output is not stalled.
// The whole pipeline holds while a result waits at the output register.
// Reset clears all valid bits and loads the tolerance registers.
`default_nettype none
`include "quadratic_root_solver_assert.svh"

module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_coef_a,
    input  wire logic [31:0] s_coef_b,
    input  wire logic [31:0] s_coef_c,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_root_low,
    output logic [31:0]      m_root_high,
    output logic [2:0]       m_root_class,
    output logic             m_overflow,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int NW = NUM_MAG_W + FRAC_BITS;
    localparam int QW = NW + 1;

    logic        en;
    logic [15:0] coef_tol_reg;
    logic [31:0] disc_tol_reg;
    logic [15:0] root_tol_reg;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_tol_reg <= COEF_TOL_RESET;
            disc_tol_reg <= DISC_TOL_RESET;
            root_tol_reg <= ROOT_TOL_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_COEF_TOL: coef_tol_reg <= cfg_data[15:0];
                CFG_DISC_TOL: disc_tol_reg <= cfg_data;
                CFG_ROOT_TOL: root_tol_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // input register
    logic        v1_reg;
    logic [31:0] a1_reg, b1_reg, c1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en) v1_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg <= s_coef_a;
            b1_reg <= s_coef_b;
            c1_reg <= s_coef_c;
        end
    end

    // products and tolerance flags
    logic        v2_reg;
    logic [63:0] bb2_reg, m2_reg;
    logic [31:0] a2_reg, b2_reg, c2_reg;
    logic        lin2_reg, bz2_reg, cz2_reg;
    logic [31:0] amag1, bmag1, cmag1;

    assign amag1 = mag32(a1_reg);
    assign bmag1 = mag32(b1_reg);
    assign cmag1 = mag32(c1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bb2_reg  <= {32'd0, bmag1} * {32'd0, bmag1};
            m2_reg   <= {32'd0, amag1} * {32'd0, cmag1};
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            c2_reg   <= c1_reg;
            lin2_reg <= amag1 <= {16'd0, coef_tol_reg};
            bz2_reg  <= bmag1 <= {16'd0, coef_tol_reg};
            cz2_reg  <= cmag1 <= {16'd0, coef_tol_reg};
        end
    end

    // discriminant and early class
    logic        v3_reg;
    logic [DISC_W-1:0] d3_reg;
    sq_side_t    side3_reg;
    logic [DISC_W-1:0] m4x, bbx, dmag;
    logic        acneg, dneg, reject;
    sq_side_t    side3_next;

    assign m4x = {m2_reg, 2'b00};
    assign bbx = {2'b00, bb2_reg};

    always_comb begin
        acneg = (a2_reg[31] ^ c2_reg[31]) && (m2_reg != 64'd0);
        dneg  = 1'b0;
        if (acneg) begin
            dmag = bbx + m4x;
        end else if (m4x > bbx) begin
            dneg = 1'b1;
            dmag = m4x - bbx;
        end else begin
            dmag = bbx - m4x;
        end
        reject = dneg && (dmag > {34'd0, disc_tol_reg});
        side3_next.a   = a2_reg;
        side3_next.b   = b2_reg;
        side3_next.c   = c2_reg;
        side3_next.lin = lin2_reg;
        priority if (lin2_reg && bz2_reg && cz2_reg) begin
            side3_next.run_div = 1'b0;
            side3_next.cls     = CLASS_ALL;
        end else if (lin2_reg && bz2_reg) begin
            side3_next.run_div = 1'b0;
            side3_next.cls     = CLASS_NONE;
        end else if (lin2_reg) begin
            side3_next.run_div = 1'b1;
            side3_next.cls     = CLASS_LINEAR;
        end else if (reject) begin
            side3_next.run_div = 1'b0;
            side3_next.cls     = CLASS_NONE;
        end else begin
            side3_next.run_div = 1'b1;
            side3_next.cls     = CLASS_TWO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en) v3_reg <= v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d3_reg    <= dneg ? '0 : dmag;
            side3_reg <= side3_next;
        end
    end

    // square root, one result bit per stage
    logic              sq_v_reg    [0:SQ_W];
    logic [DISC_W-1:0] sq_rem_reg  [0:SQ_W];
    logic [SQ_W-1:0]   sq_root_reg [0:SQ_W];
    sq_side_t          sq_side_reg [0:SQ_W];

    assign sq_v_reg[0]    = v3_reg;
    assign sq_rem_reg[0]  = d3_reg;
    assign sq_root_reg[0] = '0;
    assign sq_side_reg[0] = side3_reg;

    for (genvar gi = 0; gi < SQ_W; gi++) begin : g_sqrt
        localparam int K = SQ_W - 1 - gi;
        logic [SQ_TW-1:0] trial;
        logic             fit;

        assign trial = ({{(SQ_TW-SQ_W){1'b0}}, sq_root_reg[gi]} << (K + 1))
                     | ({{(SQ_TW-1){1'b0}}, 1'b1} << (2 * K));
        assign fit   = trial <= {{(SQ_TW-DISC_W){1'b0}}, sq_rem_reg[gi]};

        always_ff @(posedge aclk) begin
            if (!aresetn) sq_v_reg[gi+1] <= 1'b0;
            else if (en) sq_v_reg[gi+1] <= sq_v_reg[gi];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[gi+1]  <= fit ? sq_rem_reg[gi] - trial[DISC_W-1:0]
                                         : sq_rem_reg[gi];
                sq_root_reg[gi+1] <= fit ? sq_root_reg[gi] | ({{(SQ_W-1){1'b0}}, 1'b1} << K)
                                         : sq_root_reg[gi];
                sq_side_reg[gi+1] <= sq_side_reg[gi];
            end
        end
    end

    // numerator and divisor preparation
    logic        v4_reg;
    logic [NW-1:0] nq1_4_reg, nq2_4_reg;
    dv_side_t    side4_reg;
    sq_side_t    sqs;
    logic [NUM_MAG_W-1:0] bx, cx, sx, n1, n2, n1m, n2m;
    logic [31:0] am, bm;
    dv_side_t    side4_next;

    always_comb begin
        sqs = sq_side_reg[SQ_W];
        bx  = {{(NUM_MAG_W-32){sqs.b[31]}}, sqs.b};
        cx  = {{(NUM_MAG_W-32){sqs.c[31]}}, sqs.c};
        sx  = {{(NUM_MAG_W-SQ_W){1'b0}}, sq_root_reg[SQ_W]};
        am  = mag32(sqs.a);
        bm  = mag32(sqs.b);
        if (sqs.lin) begin
            n1 = -cx;
            n2 = -cx;
            side4_next.den  = {1'b0, bm};
            side4_next.neg1 = n1[NUM_MAG_W-1] ^ sqs.b[31];
            side4_next.neg2 = n2[NUM_MAG_W-1] ^ sqs.b[31];
        end else begin
            n1 = -bx - sx;
            n2 = -bx + sx;
            side4_next.den  = {am, 1'b0};
            side4_next.neg1 = n1[NUM_MAG_W-1] ^ sqs.a[31];
            side4_next.neg2 = n2[NUM_MAG_W-1] ^ sqs.a[31];
        end
        n1m = n1[NUM_MAG_W-1] ? -n1 : n1;
        n2m = n2[NUM_MAG_W-1] ? -n2 : n2;
        side4_next.run_div = sqs.run_div;
        side4_next.lin     = sqs.lin;
        side4_next.cls     = sqs.cls;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en) v4_reg <= sq_v_reg[SQ_W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nq1_4_reg <= {n1m, {FRAC_BITS{1'b0}}};
            nq2_4_reg <= {n2m, {FRAC_BITS{1'b0}}};
            side4_reg <= side4_next;
        end
    end

    // two restoring dividers, one quotient bit per stage
    logic             dv_v_reg    [0:NW];
    logic [DEN_W-1:0] dv_rem1_reg [0:NW];
    logic [DEN_W-1:0] dv_rem2_reg [0:NW];
    logic [NW-1:0]    dv_nq1_reg  [0:NW];
    logic [NW-1:0]    dv_nq2_reg  [0:NW];
    dv_side_t         dv_side_reg [0:NW];

    assign dv_v_reg[0]    = v4_reg;
    assign dv_rem1_reg[0] = '0;
    assign dv_rem2_reg[0] = '0;
    assign dv_nq1_reg[0]  = nq1_4_reg;
    assign dv_nq2_reg[0]  = nq2_4_reg;
    assign dv_side_reg[0] = side4_reg;

    for (genvar gj = 0; gj < NW; gj++) begin : g_div
        logic [DEN_W:0] t1, t2, d1, d2, dx;
        logic           ge1, ge2;

        assign dx  = {1'b0, dv_side_reg[gj].den};
        assign t1  = {dv_rem1_reg[gj], dv_nq1_reg[gj][NW-1]};
        assign t2  = {dv_rem2_reg[gj], dv_nq2_reg[gj][NW-1]};
        assign ge1 = t1 >= dx;
        assign ge2 = t2 >= dx;
        assign d1  = ge1 ? t1 - dx : t1;
        assign d2  = ge2 ? t2 - dx : t2;

        always_ff @(posedge aclk) begin
            if (!aresetn) dv_v_reg[gj+1] <= 1'b0;
            else if (en) dv_v_reg[gj+1] <= dv_v_reg[gj];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem1_reg[gj+1] <= d1[DEN_W-1:0];
                dv_rem2_reg[gj+1] <= d2[DEN_W-1:0];
                dv_nq1_reg[gj+1]  <= {dv_nq1_reg[gj][NW-2:0], ge1};
                dv_nq2_reg[gj+1]  <= {dv_nq2_reg[gj][NW-2:0], ge2};
                dv_side_reg[gj+1] <= dv_side_reg[gj];
            end
        end
    end

    // sign and order
    logic        v5_reg;
    logic signed [QW-1:0] lo5_reg, hi5_reg;
    dv_side_t    side5_reg;
    logic signed [QW-1:0] q1, q2;
    dv_side_t    dvs;

    assign dvs = dv_side_reg[NW];
    assign q1  = dvs.neg1 ? -$signed({1'b0, dv_nq1_reg[NW]}) : $signed({1'b0, dv_nq1_reg[NW]});
    assign q2  = dvs.neg2 ? -$signed({1'b0, dv_nq2_reg[NW]}) : $signed({1'b0, dv_nq2_reg[NW]});

    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (en) v5_reg <= dv_v_reg[NW];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo5_reg   <= (q1 < q2) ? q1 : q2;
            hi5_reg   <= (q1 < q2) ? q2 : q1;
            side5_reg <= dvs;
        end
    end

    // classify and saturate
    logic        m_valid_reg;
    logic [31:0] root_low_reg, root_high_reg;
    root_class_t root_class_reg;
    logic        overflow_reg;
    logic [QW-1:0] diff;
    logic        lo_fits, hi_fits;
    logic [31:0] lo_sat, hi_sat;
    logic [31:0] root_low_next, root_high_next;
    root_class_t root_class_next;
    logic        overflow_next;

    assign diff    = hi5_reg - lo5_reg;
    assign lo_fits = (&lo5_reg[QW-1:31]) || !(|lo5_reg[QW-1:31]);
    assign hi_fits = (&hi5_reg[QW-1:31]) || !(|hi5_reg[QW-1:31]);
    assign lo_sat  = lo_fits ? lo5_reg[31:0] : (lo5_reg[QW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign hi_sat  = hi_fits ? hi5_reg[31:0] : (hi5_reg[QW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    always_comb begin
        priority if (!side5_reg.run_div) begin
            root_low_next   = '0;
            root_high_next  = '0;
            root_class_next = side5_reg.cls;
            overflow_next   = 1'b0;
        end else if (side5_reg.lin) begin
            root_low_next   = lo_sat;
            root_high_next  = lo_sat;
            root_class_next = CLASS_LINEAR;
            overflow_next   = !lo_fits;
        end else begin
            root_low_next   = lo_sat;
            root_high_next  = hi_sat;
            root_class_next = (diff < {{(QW-16){1'b0}}, root_tol_reg}) ? CLASS_DOUBLE
                                                                        : CLASS_TWO;
            overflow_next   = !lo_fits || !hi_fits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (en) m_valid_reg <= v5_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            root_low_reg   <= root_low_next;
            root_high_reg  <= root_high_next;
            root_class_reg <= root_class_next;
            overflow_reg   <= overflow_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_root_low   = root_low_reg;
    assign m_root_high  = root_high_reg;
    assign m_root_class = root_class_reg;
    assign m_overflow   = overflow_reg;

    `QRS_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid, "output valid after reset")
    `QRS_ASSERT(a_no_root_zero, (m_valid && (m_root_class == CLASS_NONE || m_root_class == CLASS_ALL)) |-> (m_root_low == 32'd0 && m_root_high == 32'd0 && !m_overflow), "nonzero roots without finite root")
    `QRS_ASSERT(a_ordered, m_valid |-> ($signed(m_root_low) <= $signed(m_root_high)), "roots out of order")
    `QRS_ASSERT(a_linear_same, (m_valid && m_root_class == CLASS_LINEAR) |-> (m_root_low == m_root_high), "linear roots differ")
    `QRS_ASSERT(a_stall_holds, (m_valid && !m_ready) |=> ($stable(v5_reg) && $stable(v3_reg)), "pipeline moved during stall")

endmodule

`default_nettype wire

// ===== tb/quadratic_root_solver_checker.sv =====
// Result checker for the quadratic root solver: computes expected roots per transfer.
// Depends on qrs_pkg; watches the input, result and configuration channels.
`timescale 1ns / 100ps
`default_nettype none

module quadratic_root_solver_checker
    import qrs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [31:0] s_coef_a,
    input  wire logic [31:0] s_coef_b,
    input  wire logic [31:0] s_coef_c,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_root_low,
    input  wire logic [31:0] m_root_high,
    input  wire logic [2:0]  m_root_class,
    input  wire logic        m_overflow,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output int               class_seen [5]
);

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic [2:0]  cls;
        logic        ovf;
    } roots_t;

    localparam int FB = FRAC_BITS_DEFAULT;

    roots_t      roots_q [$];
    logic [15:0] coef_tol;
    logic [31:0] disc_tol;
    logic [15:0] root_tol;

    assign pending = roots_q.size();

    function automatic logic [31:0] clip32(input logic signed [127:0] v, inout logic ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic roots_t solve_roots(input logic [31:0] ra, rb, rc);
        logic signed [127:0] a, b, c, d, s, q1, q2, lo, hi, den;
        logic [127:0] sq, cand;
        roots_t r;
        a = $signed(ra);
        b = $signed(rb);
        c = $signed(rc);
        r = '0;
        if ((a < 0 ? -a : a) <= coef_tol) begin
            if ((b < 0 ? -b : b) <= coef_tol && (c < 0 ? -c : c) <= coef_tol) begin
                r.cls = CLASS_ALL;
            end else if ((b < 0 ? -b : b) <= coef_tol) begin
                r.cls = CLASS_NONE;
            end else begin
                q1 = (-c * (128'sd1 <<< FB)) / b;
                r.lo = clip32(q1, r.ovf);
                r.hi = r.lo;
                r.cls = CLASS_LINEAR;
            end
        end else begin
            d = b * b - 128'sd4 * a * c;
            if (d < 0 && -d > $signed({96'd0, disc_tol})) begin
                r.cls = CLASS_NONE;
            end else begin
                if (d < 0) d = 0;
                sq = 0;
                for (int k = 33; k >= 0; k--) begin
                    cand = sq | (128'd1 << k);
                    if (cand * cand <= d) sq = cand;
                end
                s = sq;
                den = 2 * a;
                q1 = ((-b - s) * (128'sd1 <<< FB)) / den;
                q2 = ((-b + s) * (128'sd1 <<< FB)) / den;
                lo = q1 < q2 ? q1 : q2;
                hi = q1 < q2 ? q2 : q1;
                r.cls = (hi - lo < $signed({112'd0, root_tol})) ? CLASS_DOUBLE : CLASS_TWO;
                r.lo = clip32(lo, r.ovf);
                r.hi = clip32(hi, r.ovf);
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        roots_t want;
        if (!aresetn) begin
            coef_tol   <= COEF_TOL_RESET;
            disc_tol   <= DISC_TOL_RESET;
            root_tol   <= ROOT_TOL_RESET;
            fail_count <= 0;
            roots_q.delete();
            for (int k = 0; k < 5; k++) class_seen[k] <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_COEF_TOL: coef_tol <= cfg_data[15:0];
                    CFG_DISC_TOL: disc_tol <= cfg_data;
                    CFG_ROOT_TOL: root_tol <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) roots_q.push_back(solve_roots(s_coef_a, s_coef_b, s_coef_c));
            if (m_valid && m_ready) begin
                if (roots_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result transfer at %0t", $realtime);
                    fail_count <= fail_count + 1;
                end else begin
                    want = roots_q.pop_front();
                    if (m_root_class < 5) class_seen[m_root_class] <= class_seen[m_root_class] + 1;
                    if (want != {m_root_low, m_root_high, m_root_class, m_overflow}) begin
                        if (fail_count < 10)
                            $display("mismatch: exp lo=%h hi=%h cls=%0d ovf=%b got lo=%h hi=%h cls=%0d ovf=%b",
                                want.lo, want.hi, want.cls, want.ovf,
                                m_root_low, m_root_high, m_root_class, m_overflow);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_quadratic_root_solver.sv =====
// Testbench top for the quadratic root solver: clock, reset, stimulus and verdict.
// Depends on qrs_pkg, quadratic_root_solver and quadratic_root_solver_checker.
`timescale 1ns / 100ps
`default_nettype none

module tb_quadratic_root_solver
    import qrs_pkg::*;
();

    localparam int LATENCY     = 75 + FRAC_BITS_DEFAULT;
    localparam int RAND_ITEMS  = 1300;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_coef_a = '0;
    logic [31:0] s_coef_b = '0;
    logic [31:0] s_coef_c = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_root_low;
    logic [31:0] m_root_high;
    logic [2:0]  m_root_class;
    logic        m_overflow;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int fail_count;
    int pending;
    int class_seen [5];
    int cycles = 0;
    int sent = 0;
    bit hold_long = 1'b0;

    always #5 aclk = ~aclk;

    quadratic_root_solver u_top (.*);

    quadratic_root_solver_checker u_checker (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("quadratic_root_solver test failed");
            $finish;
        end
    end

    // receiver: random stall pattern, with long hold-offs requested after bursts that end with 301 to 359 sent
    initial begin
        int hold;
        forever begin
            @(posedge aclk);
            if (hold_long) begin
                m_ready <= 1'b0;
                for (hold = 0; hold < 400; hold++) @(posedge aclk);
                hold_long = 1'b0;
            end
            case ($urandom_range(0, 3))
                0: m_ready <= 1'b0;
                1: m_ready <= ($urandom_range(0, 1) == 1);
                default: m_ready <= 1'b1;
            endcase
        end
    end

    task automatic send_coefs(input logic [31:0] a, b, c);
        s_valid  <= 1'b1;
        s_coef_a <= a;
        s_coef_b <= b;
        s_coef_c <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_coef(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 8'hFF)) - 128;
            2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            3: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
            default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
        endcase
    endfunction

    task automatic random_phase(input int n);
        int burst;
        logic [31:0] a, b, c, r;
        while (n > 0) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                a = pick_coef($urandom_range(0, 4));
                b = pick_coef($urandom_range(0, 4));
                c = pick_coef($urandom_range(0, 4));
                case ($urandom_range(0, 7))
                    0: a = $urandom_range(0, 1) ? 32'd0 : -32'sd1;
                    1: begin
                        // build a double root: b^2 = 4ac while |r| <= 181 (larger r wraps c)
                        r = $signed($urandom_range(0, 511)) - 256;
                        a = 32'h0001_0000;
                        b = -2 * r * 32'h0001_0000;
                        c = r * r * 32'h0001_0000;
                    end
                    default: ;
                endcase
                send_coefs(a, b, c);
                n--;
                if (n == 0) break;
            end
            if (sent > 300 && sent < 360 && !hold_long) hold_long = 1'b1;
            idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_coefs(32'd0, 32'd0, 32'd0);
        send_coefs(32'd0, 32'd0, 32'h0001_0000);
        send_coefs(32'd0, 32'h0002_0000, 32'hFFFC_0000);
        send_coefs(32'd1, 32'h0000_0001, 32'h7FFF_FFFF);
        send_coefs(32'h0001_0000, 32'd0, 32'hFFFF_0000);
        send_coefs(32'h0001_0000, 32'd0, 32'h0001_0000);
        send_coefs(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);
        send_coefs(32'h0001_0000, 32'd0, 32'd1);
        send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_coefs(32'd2, 32'h7FFF_FFFF, 32'h8000_0000);
        send_coefs(32'hFFFF_FFFE, 32'h8000_0000, 32'h0001_0000);
        send_coefs(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        send_coefs(32'h0003_0000, 32'hFFFB_0000, 32'h0001_8000);
        drain();

        write_reg(CFG_COEF_TOL, 32'h0000_FFFF);
        write_reg(CFG_DISC_TOL, 32'hFFFF_FFFF);
        write_reg(CFG_ROOT_TOL, 32'h0000_FFFF);
        random_phase(RAND_ITEMS / 4);
        drain();

        write_reg(CFG_COEF_TOL, 32'd0);
        write_reg(CFG_DISC_TOL, 32'd0);
        write_reg(CFG_ROOT_TOL, 32'd0);
        random_phase(RAND_ITEMS / 4);
        drain();

        write_reg(CFG_COEF_TOL, $urandom_range(0, 16'hFFFF));
        write_reg(CFG_DISC_TOL, $urandom);
        write_reg(CFG_ROOT_TOL, $urandom_range(0, 16'hFFFF));
        random_phase(RAND_ITEMS / 4);
        drain();

        write_reg(CFG_COEF_TOL, 32'd1);
        write_reg(CFG_DISC_TOL, 32'd42950);
        write_reg(CFG_ROOT_TOL, 32'd1);
        random_phase(RAND_ITEMS / 4);
        drain();

        $display("sent %0d coefficient sets over four tolerance settings", sent);
        $display("classes none/two/linear/double/all: %0d %0d %0d %0d %0d",
            class_seen[CLASS_NONE], class_seen[CLASS_TWO], class_seen[CLASS_LINEAR],
            class_seen[CLASS_DOUBLE], class_seen[CLASS_ALL]);
        if (fail_count == 0) begin
            $display("quadratic_root_solver test passed");
        end else begin
            $display("quadratic_root_solver test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
